>>> src/assert_macros.svh
// Assertion macros shared by the checker modules.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent in a cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/rmea_pkg.sv
// Shared constants, codes and the arctangent table for the Euler angle unit.
// Used by every module of the unit and by its checker.
package rmea_pkg;

   // Number of CORDIC micro-rotations (8 to 24).
   localparam int CORDIC_ITERATIONS = 16;

   // Datapath widths.
   localparam int CW = 34;  // CORDIC x and y
   localparam int ZW = 28;  // CORDIC angle accumulator, units of 2^-24 rad
   localparam int RW = 50;  // square root radicand
   localparam int SQRT_STAGES = 25;
   localparam int ROOT_W = SQRT_STAGES;

   // Angle constants.
   localparam logic signed [ZW-1:0] PI_FINE = ZW'(52707179);
   localparam logic signed [15:0] PI_Q = 16'sd25736;
   localparam logic signed [15:0] HALF_PI_Q = 16'sd12868;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   // Pole codes.
   localparam logic [1:0] POLE_NORMAL = 2'd0;
   localparam logic [1:0] POLE_LOWER = 2'd1;
   localparam logic [1:0] POLE_UPPER = 2'd2;

   // atan(2^-i) in units of 2^-24 rad.
   function automatic logic signed [ZW-1:0] atan_val(input int i);
      logic signed [ZW-1:0] v;
      case (i)
         0: v = ZW'(13176795);
         1: v = ZW'(7778716);
         2: v = ZW'(4110060);
         3: v = ZW'(2086331);
         4: v = ZW'(1047214);
         5: v = ZW'(524117);
         6: v = ZW'(262123);
         7: v = ZW'(131069);
         8: v = ZW'(65536);
         9: v = ZW'(32768);
         10: v = ZW'(16384);
         11: v = ZW'(8192);
         12: v = ZW'(4096);
         13: v = ZW'(2048);
         14: v = ZW'(1024);
         15: v = ZW'(512);
         16: v = ZW'(256);
         17: v = ZW'(128);
         18: v = ZW'(64);
         19: v = ZW'(32);
         20: v = ZW'(16);
         21: v = ZW'(8);
         22: v = ZW'(4);
         23: v = ZW'(2);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> src/rmea_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on rmea_pkg.
module rmea_isqrt import rmea_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  logic [RW-1:0]     rad_in,
   output logic [ROOT_W-1:0] root_out
);

   localparam int TOP_BIT = 2 * (SQRT_STAGES - 1);

   logic [RW-1:0] v_ff [SQRT_STAGES];
   logic [RW-1:0] r_ff [SQRT_STAGES];
   logic [RW-1:0] v_in [SQRT_STAGES];
   logic [RW-1:0] r_in [SQRT_STAGES];

   // Each stage tries one root bit against the remaining radicand.
   always_comb begin
      logic [RW-1:0] v_prev;
      logic [RW-1:0] r_prev;
      logic [RW-1:0] bit_c;
      logic [RW-1:0] trial;
      for (int j = 0; j < SQRT_STAGES; j++) begin
         v_prev = (j == 0) ? rad_in : v_ff[(j == 0) ? 0 : j - 1];
         r_prev = (j == 0) ? '0 : r_ff[(j == 0) ? 0 : j - 1];
         bit_c = RW'(1) << (TOP_BIT - 2 * j);
         trial = r_prev + bit_c;
         if (v_prev >= trial) begin
            v_in[j] = v_prev - trial;
            r_in[j] = (r_prev >> 1) + bit_c;
         end else begin
            v_in[j] = v_prev;
            r_in[j] = r_prev >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < SQRT_STAGES; j++) begin
            v_ff[j] <= v_in[j];
            r_ff[j] <= r_in[j];
         end
      end
   end

   assign root_out = r_ff[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

>>> src/rmea_cordic.sv
// Pipelined vectoring CORDIC computing atan2 in signed Q3.13 radians.
// Depends on rmea_pkg. The folded input, every micro-rotation and the rounded angle are registered.
module rmea_cordic import rmea_pkg::*; (
   input  logic                 clock,
   input  logic                 adv,
   input  logic signed [CW-1:0] y_in,
   input  logic signed [CW-1:0] x_in,
   input  logic                 neg_in,
   output logic signed [15:0]   angle_out
);

   localparam int NS = CORDIC_ITERATIONS + 1;

   logic signed [CW-1:0] x_ff [NS];
   logic signed [CW-1:0] y_ff [NS];
   logic signed [ZW-1:0] z_ff [NS];
   logic                 zero_ff [NS];
   logic                 neg_ff [NS];
   logic signed [CW-1:0] x_in0;
   logic signed [CW-1:0] y_in0;
   logic signed [ZW-1:0] z_in0;
   logic signed [15:0]   angle_ff;
   logic signed [15:0]   angle_in;

   // Fold the left half plane onto the right and seed the angle with +-pi.
   always_comb begin
      x_in0 = x_in;
      y_in0 = y_in;
      z_in0 = '0;
      if (x_in[CW-1]) begin
         x_in0 = -x_in;
         y_in0 = -y_in;
         z_in0 = y_in[CW-1] ? -PI_FINE : PI_FINE;
      end
   end

   // Micro-rotation stages, one per register.
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= x_in0;
         y_ff[0] <= y_in0;
         z_ff[0] <= z_in0;
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         neg_ff[0] <= neg_in;
         for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
            if (!y_ff[i][CW-1] && (y_ff[i] != '0)) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_val(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_val(i);
            end
            zero_ff[i+1] <= zero_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
         angle_ff <= angle_in;
      end
   end

   // Round to Q3.13 with ties up, clamp to +-pi, then force zero for a zero vector or apply the sign flip.
   always_comb begin
      logic signed [ZW:0]   rnd;
      logic signed [ZW:0]   q;
      logic signed [15:0]   qc;
      rnd = {z_ff[NS-1][ZW-1], z_ff[NS-1]} + (ZW + 1)'(1024);
      q = rnd >>> 11;
      if (q > (ZW + 1)'(PI_Q)) begin
         qc = PI_Q;
      end else if (q < -(ZW + 1)'(PI_Q)) begin
         qc = -PI_Q;
      end else begin
         qc = q[15:0];
      end
      if (zero_ff[NS-1]) begin
         angle_in = '0;
      end else if (neg_ff[NS-1]) begin
         angle_in = -qc;
      end else begin
         angle_in = qc;
      end
   end

   assign angle_out = angle_ff;

endmodule

>>> src/rotation_matrix_to_euler_angles_unit.sv
// Rotation matrix to Euler angles, fully pipelined.
// Path from accept to result: input register, radicand register, a 25-stage square root
// feeding the y-angle CORDIC, then the output register; x and z results wait alongside.
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// Reset: synchronous, active high, clears the valid bits only.
module rotation_matrix_to_euler_angles_unit import rmea_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_angle_x,
   output logic signed [15:0] rsp_angle_y,
   output logic signed [15:0] rsp_angle_z,
   output logic [1:0]         rsp_pole_case
);

   localparam int LC = CORDIC_ITERATIONS + 2;
   localparam int DLY = SQRT_STAGES + 1;
   localparam int NV = LC + SQRT_STAGES + 3;
   localparam int NP = LC + DLY;

   logic                 adv;
   logic                 vld_ff [NV];
   logic signed [15:0]   a_m00_ff, a_m10_ff, a_m11_ff, a_m12_ff;
   logic signed [15:0]   a_m20_ff, a_m21_ff, a_m22_ff;
   logic [1:0]           a_pole;
   logic signed [31:0]   m20_sq;
   logic signed [33:0]   rad_diff;
   logic [RW-1:0]        rad_ff;
   logic [ROOT_W-1:0]    root;
   logic signed [15:0]   m20_dly_ff [DLY];
   logic [1:0]           pole_dly_ff [NP];
   logic signed [15:0]   x_dly_ff [DLY];
   logic signed [15:0]   z_dly_ff [DLY];
   logic signed [CW-1:0] cz_y, cz_x, cx_y, cx_x, cy_y, cy_x;
   logic                 cz_neg;
   logic signed [15:0]   ang_x, ang_y, ang_z;
   logic signed [15:0]   rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [1:0]           rsp_pole_ff;

   // The pipeline moves unless a finished result is held off.
   assign adv = !(vld_ff[NV-1] && rsp_stall);
   assign req_stall = !adv;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NV; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < NV; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (adv) begin
         a_m00_ff <= req_m00;
         a_m10_ff <= req_m10;
         a_m11_ff <= req_m11;
         a_m12_ff <= req_m12;
         a_m20_ff <= req_m20;
         a_m21_ff <= req_m21;
         a_m22_ff <= req_m22;
      end
   end

   // Pole test on m20.
   always_comb begin
      if (a_m20_ff <= -ONE_Q14) begin
         a_pole = POLE_LOWER;
      end else if (a_m20_ff >= ONE_Q14) begin
         a_pole = POLE_UPPER;
      end else begin
         a_pole = POLE_NORMAL;
      end
   end

   // Radicand (1 - m20^2) scaled so that its root is in units of 2^-24.
   assign m20_sq = a_m20_ff * a_m20_ff;
   assign rad_diff = 34'sd268435456 - {{2{m20_sq[31]}}, m20_sq};

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff <= {1'b0, rad_diff[28:0], 20'b0};
      end
   end

   rmea_isqrt u_isqrt (
      .clock    (clock),
      .adv      (adv),
      .rad_in   (rad_ff),
      .root_out (root)
   );

   // Operands of the z and x arctangents, scaled to 2^-28 units.
   always_comb begin
      cz_neg = 1'b0;
      case (a_pole)
         POLE_LOWER: begin
            cz_y = -{{4{a_m12_ff[15]}}, a_m12_ff, 14'b0};
            cz_x = {{4{a_m11_ff[15]}}, a_m11_ff, 14'b0};
            cz_neg = 1'b1;
         end
         POLE_UPPER: begin
            cz_y = {{4{a_m12_ff[15]}}, a_m12_ff, 14'b0};
            cz_x = {{4{a_m11_ff[15]}}, a_m11_ff, 14'b0};
         end
         default: begin
            cz_y = -{{4{a_m10_ff[15]}}, a_m10_ff, 14'b0};
            cz_x = {{4{a_m00_ff[15]}}, a_m00_ff, 14'b0};
         end
      endcase
   end

   assign cx_y = -{{4{a_m21_ff[15]}}, a_m21_ff, 14'b0};
   assign cx_x = {{4{a_m22_ff[15]}}, a_m22_ff, 14'b0};

   // Operands of the y arctangent once the root is ready.
   assign cy_y = {{8{m20_dly_ff[DLY-1][15]}}, m20_dly_ff[DLY-1], 10'b0};
   assign cy_x = {{(CW - ROOT_W){1'b0}}, root};

   rmea_cordic u_cordic_z (
      .clock     (clock),
      .adv       (adv),
      .y_in      (cz_y),
      .x_in      (cz_x),
      .neg_in    (cz_neg),
      .angle_out (ang_z)
   );

   rmea_cordic u_cordic_x (
      .clock     (clock),
      .adv       (adv),
      .y_in      (cx_y),
      .x_in      (cx_x),
      .neg_in    (1'b0),
      .angle_out (ang_x)
   );

   rmea_cordic u_cordic_y (
      .clock     (clock),
      .adv       (adv),
      .y_in      (cy_y),
      .x_in      (cy_x),
      .neg_in    (1'b0),
      .angle_out (ang_y)
   );

   // Delay lines that keep m20, the pole code and the early angles aligned.
   always_ff @(posedge clock) begin
      if (adv) begin
         m20_dly_ff[0] <= a_m20_ff;
         x_dly_ff[0] <= ang_x;
         z_dly_ff[0] <= ang_z;
         for (int k = 1; k < DLY; k++) begin
            m20_dly_ff[k] <= m20_dly_ff[k-1];
            x_dly_ff[k] <= x_dly_ff[k-1];
            z_dly_ff[k] <= z_dly_ff[k-1];
         end
         pole_dly_ff[0] <= a_pole;
         for (int k = 1; k < NP; k++) begin
            pole_dly_ff[k] <= pole_dly_ff[k-1];
         end
      end
   end

   // Output register with the pole overrides.
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pole_ff <= pole_dly_ff[NP-1];
         rsp_z_ff <= z_dly_ff[DLY-1];
         case (pole_dly_ff[NP-1])
            POLE_LOWER: begin
               rsp_x_ff <= '0;
               rsp_y_ff <= -HALF_PI_Q;
            end
            POLE_UPPER: begin
               rsp_x_ff <= '0;
               rsp_y_ff <= HALF_PI_Q;
            end
            default: begin
               rsp_x_ff <= x_dly_ff[DLY-1];
               rsp_y_ff <= ang_y;
            end
         endcase
      end
   end

   assign rsp_valid = vld_ff[NV-1];
   assign rsp_angle_x = rsp_x_ff;
   assign rsp_angle_y = rsp_y_ff;
   assign rsp_angle_z = rsp_z_ff;
   assign rsp_pole_case = rsp_pole_ff;

endmodule

>>> src/rmea_checker.sv
// Port-level checker for the Euler angle unit, bound to the top level.
// Depends on rmea_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rmea_port_checker import rmea_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_angle_x,
   input logic signed [15:0] rsp_angle_y,
   input logic signed [15:0] rsp_angle_z,
   input logic [1:0]         rsp_pole_case
);

   logic        pole_rsp;
   logic        y_at_pole;
   logic [49:0] rsp_fields;

   // A pole result on the port, and whether its y angle sits at the matching pole.
   assign pole_rsp = rsp_valid && (rsp_pole_case != POLE_NORMAL);
   assign y_at_pole = (rsp_pole_case == POLE_LOWER && rsp_angle_y == -HALF_PI_Q) ||
                      (rsp_pole_case == POLE_UPPER && rsp_angle_y == HALF_PI_Q);
   assign rsp_fields = {rsp_angle_x, rsp_angle_y, rsp_angle_z, rsp_pole_case};

   // Pole results carry a zero x angle.
   `ASSERT_IMPLY(pole_x_zero, clock, reset, pole_rsp, rsp_angle_x == '0)

   // Pole results carry y at exactly plus or minus pi/2.
   `ASSERT_IMPLY(pole_y_fixed, clock, reset, pole_rsp, y_at_pole)

   // The z angle never leaves the range of +-pi.
   `ASSERT_IMPLY(z_in_range, clock, reset, rsp_valid, (rsp_angle_z <= PI_Q) && (rsp_angle_z >= -PI_Q))

   // A stalled result stays on the port unchanged.
   `ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fields))

endmodule

bind rotation_matrix_to_euler_angles_unit rmea_port_checker u_rmea_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_angle_x   (rsp_angle_x),
   .rsp_angle_y   (rsp_angle_y),
   .rsp_angle_z   (rsp_angle_z),
   .rsp_pole_case (rsp_pole_case)
);

>>> tb/rmea_checker.sv
// Checker for the rotation matrix to Euler angle unit: predicts each result
// from the accepted request and compares it field by field. Depends on rmea_pkg.
`timescale 1ns / 1ps

module rmea_checker import rmea_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_angle_x,
   input  logic signed [15:0] rsp_angle_y,
   input  logic signed [15:0] rsp_angle_z,
   input  logic [1:0]         rsp_pole_case,
   output int                 fail_count,
   output int                 pending_count,
   output int                 pole_seen [3]
);

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic [1:0]         pole;
   } angles_type;

   angles_type angle_queue[$];

   // Table of atan(2^-i) in units of 2^-24 rad.
   localparam longint ATAN_FINE [24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2};

   // Vectoring-mode arctangent, rounded to Q3.13 and clamped to +-pi.
   function automatic longint vector_angle(input longint yi, input longint xi);
      longint x, y, z, base, dx, dy, q;
      x = xi;
      y = yi;
      z = 0;
      base = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         base = (y < 0) ? -52707179 : 52707179;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y > 0) begin
            x += dy;
            y -= dx;
            z += ATAN_FINE[i];
         end else begin
            x -= dy;
            y += dx;
            z -= ATAN_FINE[i];
         end
      end
      q = (base + z + 1024) >>> 11;
      if (q > PI_Q) q = PI_Q;
      if (q < -PI_Q) q = -PI_Q;
      return q;
   endfunction

   // Bitwise integer square root.
   function automatic longint int_root(input longint v);
      longint res, b;
      res = 0;
      b = 64'sh4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic angles_type euler_of_matrix(input longint m00, m10, m11, m12,
                                                  m20, m21, m22);
      angles_type a;
      longint s;
      if (m20 <= -longint'(ONE_Q14)) begin
         a.az = 16'(-vector_angle(-m12 * 16384, m11 * 16384));
         a.ay = -HALF_PI_Q;
         a.ax = '0;
         a.pole = POLE_LOWER;
      end else if (m20 >= longint'(ONE_Q14)) begin
         a.az = 16'(vector_angle(m12 * 16384, m11 * 16384));
         a.ay = HALF_PI_Q;
         a.ax = '0;
         a.pole = POLE_UPPER;
      end else begin
         s = int_root((268435456 - m20 * m20) <<< 20);
         a.az = 16'(vector_angle(-m10 * 16384, m00 * 16384));
         a.ay = 16'(vector_angle(m20 * 1024, s));
         a.ax = 16'(vector_angle(-m21 * 16384, m22 * 16384));
         a.pole = POLE_NORMAL;
      end
      return a;
   endfunction

   // Predict on accepted requests, compare on accepted results.
   always @(posedge clock) begin
      angles_type e;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
         pole_seen <= '{0, 0, 0};
         angle_queue.delete();
      end else begin
         if (req_valid && !req_stall)
            angle_queue.push_back(euler_of_matrix(req_m00, req_m10, req_m11, req_m12,
                                                  req_m20, req_m21, req_m22));
         if (rsp_valid && !rsp_stall) begin
            if (angle_queue.size() == 0) begin
               $error("result with no request outstanding");
               errs++;
            end else begin
               e = angle_queue.pop_front();
               if (rsp_pole_case < 3) pole_seen[rsp_pole_case] <= pole_seen[rsp_pole_case] + 1;
               if (rsp_angle_x !== e.ax) begin
                  $error("angle_x expected %0d actual %0d", e.ax, rsp_angle_x);
                  errs++;
               end
               if (rsp_angle_y !== e.ay) begin
                  $error("angle_y expected %0d actual %0d", e.ay, rsp_angle_y);
                  errs++;
               end
               if (rsp_angle_z !== e.az) begin
                  $error("angle_z expected %0d actual %0d", e.az, rsp_angle_z);
                  errs++;
               end
               if (rsp_pole_case !== e.pole) begin
                  $error("pole_case expected %0d actual %0d", e.pole, rsp_pole_case);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending_count <= angle_queue.size();
      end
   end

endmodule

>>> tb/tb_rotation_matrix_to_euler_angles_unit.sv
// Testbench top for the rotation matrix to Euler angle unit: drives requests
// and result stalls, and gives the verdict. Depends on rmea_pkg and rmea_checker.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_euler_angles_unit;
   import rmea_pkg::*;

   localparam int RANDOM_COUNT = 1880;
   localparam int WATCHDOG_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_m00 = '0, req_m10 = '0, req_m11 = '0, req_m12 = '0;
   logic signed [15:0] req_m20 = '0, req_m21 = '0, req_m22 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_angle_x, rsp_angle_y, rsp_angle_z;
   logic [1:0] rsp_pole_case;
   int fail_count, pending_count;
   int pole_seen [3];
   int sent_count = 0;
   int idle_cycles = 0;
   bit quiet_tail = 0;
   bit hold_done = 0;
   bit hold_now = 0;

   rotation_matrix_to_euler_angles_unit i_dut (.*);

   rmea_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // One request: present it, wait for acceptance, then outside the quiet tail sometimes drop valid for a random gap.
   task automatic send_matrix(input int a, b, c, d, e, f, g);
      req_valid <= 1'b1;
      req_m00 <= 16'(a); req_m10 <= 16'(b); req_m11 <= 16'(c); req_m12 <= 16'(d);
      req_m20 <= 16'(e); req_m21 <= 16'(f); req_m22 <= 16'(g);
      do @(posedge clock); while (req_stall);
      sent_count++;
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   // Field values biased toward the extremes, values near zero and the pole boundary.
   function automatic logic [15:0] pick_elem();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 1) ? 32767 : -32768);
         1: return 16'($urandom_range(16380, 16388) * ($urandom_range(0, 1) ? 1 : -1));
         2: return 16'($urandom_range(0, 3) - 2);
         default: return 16'($urandom);
      endcase
   endfunction

   // Stall the result side in bursts; one long hold-off fills the pipeline.
   initial begin
      @(negedge clock);
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!hold_done && sent_count > 400) begin
            hold_done = 1;
            hold_now = 1;
            rsp_stall <= 1'b1;
            repeat (200) @(negedge clock);
            hold_now = 0;
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any acceptance.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || hold_now) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tb_rotation_matrix_to_euler_angles_unit: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [15:0] v;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // Directed: extremes, zero vector, negative real axis, both poles.
      send_matrix(0, 0, 0, 0, 0, 0, 0);
      send_matrix(-16384, 0, 16384, 0, 0, 0, -16384);
      send_matrix(16384, 16384, 0, 0, 16383, 16384, 0);
      send_matrix(0, 0, 16384, 0, -16383, 0, 0);
      send_matrix(0, 0, -16384, 0, 16384, 0, 0);
      send_matrix(0, 0, -16384, 0, -16384, 0, 0);
      send_matrix(0, 0, 0, 0, 32767, 0, 0);
      send_matrix(0, 0, 0, 0, -32768, 0, 0);
      send_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767);
      send_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
      send_matrix(-32768, 32767, 16384, -16384, 16384, -32768, 32767);
      send_matrix(-32768, 0, 0, 0, 0, 0, -32768);
      send_matrix(-1, 1, 1, -1, -16384, 1, -1);
      send_matrix(-1, -1, -1, 1, 16384, -1, -1);
      send_matrix(11585, -11585, 11585, 11585, 8192, -11585, 11585);
      send_matrix(16384, 0, 0, 16384, -1, 0, 16384);
      send_matrix(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      send_matrix(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      // Random matrices; the tail runs without idling on either side.
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == RANDOM_COUNT - 200) quiet_tail = 1;
         v = ($urandom_range(0, 3) == 0) ? pick_elem() : 16'($urandom_range(0, 32768) - 16384);
         send_matrix(pick_elem(), pick_elem(), pick_elem(), pick_elem(), v,
                     pick_elem(), pick_elem());
      end
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (CORDIC_ITERATIONS + 40) @(posedge clock);
      $display("Sent %0d matrices: %0d normal, %0d lower pole, %0d upper pole results.",
               sent_count, pole_seen[0], pole_seen[1], pole_seen[2]);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_rotation_matrix_to_euler_angles_unit: PASS");
      else
         $display("tb_rotation_matrix_to_euler_angles_unit: FAIL");
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/rmea_pkg.sv
src/rmea_isqrt.sv
src/rmea_cordic.sv
src/rotation_matrix_to_euler_angles_unit.sv
src/rmea_checker.sv
tb/rmea_checker.sv
tb/tb_rotation_matrix_to_euler_angles_unit.sv
